>>> hdl/ieee_logb_exponent_extract_macros.svh
// assertion macros
`ifndef IEEE_LOGB_EXPONENT_EXTRACT_MACROS_SVH
`define IEEE_LOGB_EXPONENT_EXTRACT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ILE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ILE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/ile_pkg.sv
package ile_pkg;

    typedef enum logic [1:0] {
        OP_F32  = 2'd0,
        OP_F64  = 2'd1,
        OP_F128 = 2'd2,
        OP_RSVD = 2'd3
    } t_opcode;

    localparam logic [31:0] POS_INF32 = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF32 = 32'hFF80_0000;
    localparam logic [31:0] QNAN_RST  = 32'h7FC0_0000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] value_high;
        logic [63:0] value_low;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        divide_by_zero;
    } t_out_item;

    // special-case class of one operand
    typedef enum logic [2:0] {
        CLS_NAN_SELF,
        CLS_NAN_CFG,
        CLS_INF,
        CLS_ZERO,
        CLS_FINITE
    } t_class;

    typedef struct packed {
        t_class       cls;
        logic signed [15:0] expo;
        logic [31:0]  nan_bits;
    } t_decode;

    // leading one position of a 64-bit word
    function automatic logic [5:0] msb64(input logic [63:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> hdl/ile_if.sv
interface ile_in_if;
    import ile_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ile_out_if;
    import ile_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ile_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/ile_decode.sv
module ile_decode
    import ile_pkg::*;
(
    input  t_in_item i_item,
    output t_decode  o_dec
);
    logic [7:0]  ex32;
    logic [22:0] fr32;
    logic [10:0] ex64;
    logic [51:0] fr64;
    logic [14:0] ex128;
    logic [47:0] frh;
    logic        frz;
    logic [6:0]  p128;

    always_comb begin
        ex32  = i_item.value_low[30:23];
        fr32  = i_item.value_low[22:0];
        ex64  = i_item.value_low[62:52];
        fr64  = i_item.value_low[51:0];
        ex128 = i_item.value_high[62:48];
        frh   = i_item.value_high[47:0];
        frz   = (frh == '0) && (i_item.value_low == '0);
        p128  = (frh != '0) ? (7'd64 + {1'b0, msb64({16'd0, frh})})
                            : {1'b0, msb64(i_item.value_low)};
        o_dec.nan_bits = i_item.value_low[31:0];
        o_dec.expo     = '0;
        o_dec.cls      = CLS_FINITE;
        unique case (t_opcode'(i_item.opcode))
            OP_F32: begin
                if (ex32 == 8'hFF) begin
                    o_dec.cls = (fr32 != '0) ? CLS_NAN_SELF : CLS_INF;
                end else if (ex32 == '0 && fr32 == '0) begin
                    o_dec.cls = CLS_ZERO;
                end else if (ex32 == '0) begin
                    o_dec.expo = 16'(signed'({10'd0, msb64({41'd0, fr32})})) - 16'sd149;
                end else begin
                    o_dec.expo = 16'(signed'({8'd0, ex32})) - 16'sd127;
                end
            end
            OP_F64: begin
                if (ex64 == 11'h7FF) begin
                    o_dec.cls = (fr64 != '0) ? CLS_NAN_CFG : CLS_INF;
                end else if (ex64 == '0 && fr64 == '0) begin
                    o_dec.cls = CLS_ZERO;
                end else if (ex64 == '0) begin
                    o_dec.expo = 16'(signed'({10'd0, msb64({12'd0, fr64})})) - 16'sd1074;
                end else begin
                    o_dec.expo = 16'(signed'({5'd0, ex64})) - 16'sd1023;
                end
            end
            OP_F128, OP_RSVD: begin
                if (ex128 == 15'h7FFF) begin
                    o_dec.cls = frz ? CLS_INF : CLS_NAN_CFG;
                end else if (ex128 == '0 && frz) begin
                    o_dec.cls = CLS_ZERO;
                end else if (ex128 == '0) begin
                    o_dec.expo = 16'(signed'({9'd0, p128})) - 16'sd16494;
                end else begin
                    o_dec.expo = 16'(signed'({1'b0, ex128})) - 16'sd16383;
                end
            end
            default: begin
                o_dec.cls = CLS_FINITE;
            end
        endcase
    end
endmodule

>>> hdl/ile_pack.sv
module ile_pack
    import ile_pkg::*;
(
    input  t_decode     i_dec,
    input  logic [31:0] i_qnan,
    output t_out_item   o_item
);
    logic        neg;
    logic [14:0] mag;
    logic [5:0]  pos;
    logic [3:0]  p;
    logic [31:0] fbits;

    always_comb begin
        neg   = i_dec.expo[15];
        mag   = neg ? 15'(-i_dec.expo) : i_dec.expo[14:0];
        pos   = msb64({49'd0, mag});
        p     = pos[3:0];
        fbits = '0;
        if (mag != '0) begin
            fbits = {neg, 8'(8'd127 + {4'd0, p}), 23'(({8'd0, mag} << (5'd23 - {1'b0, p})))};
        end
        o_item.divide_by_zero = 1'b0;
        unique case (i_dec.cls)
            CLS_NAN_SELF: o_item.result_bits = i_dec.nan_bits;
            CLS_NAN_CFG:  o_item.result_bits = i_qnan;
            CLS_INF:      o_item.result_bits = POS_INF32;
            CLS_ZERO: begin
                o_item.result_bits    = NEG_INF32;
                o_item.divide_by_zero = 1'b1;
            end
            default:      o_item.result_bits = fbits;
        endcase
    end
endmodule

>>> hdl/ieee_logb_exponent_extract.sv
// path: an accepted input goes into the input reg, then its result into the result reg
// throughput: one item per cycle while out_ch.ready does not stall, set by the single-pass decode and pack logic
// a stalled result register holds while the input register keeps one item
// reset: synchronous active-low clears valid flags and sets the quiet nan register
module ieee_logb_exponent_extract
    import ile_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ile_in_if.sink    in_ch,
    ile_out_if.source out_ch,
    ile_cfg_if.sink   cfg_ch
);
`include "ieee_logb_exponent_extract_macros.svh"

    logic        r_in_vld;
    t_in_item    r_in;
    logic        r_out_vld;
    t_out_item   r_out;
    logic [31:0] r_qnan;
    t_decode     dec;
    t_out_item   res;
    logic        adv;

    ile_decode u_dec (.i_item(r_in), .o_dec(dec));
    ile_pack   u_pack (.i_dec(dec), .i_qnan(r_qnan), .o_item(res));

    assign adv          = !r_out_vld || out_ch.ready;
    assign in_ch.ready  = !r_in_vld || adv;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_out_vld;
    assign out_ch.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_qnan    <= QNAN_RST;
        end else begin
            if (cfg_ch.valid) begin
                r_qnan <= cfg_ch.data;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    r_out <= res;
                end
            end
            if (in_ch.ready) begin
                r_in_vld <= in_ch.valid;
                if (in_ch.valid) begin
                    r_in <= in_ch.data;
                end
            end
        end
    end

    `ILE_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_out_vld && !out_ch.ready, r_out_vld && $stable(r_out))
    `ILE_ASSERT_IMP(a_dbz, i_clk, i_rst_n, r_out_vld && r_out.divide_by_zero, r_out.result_bits == NEG_INF32)
    `ILE_ASSERT_NXT(a_move, i_clk, i_rst_n, r_in_vld && adv, r_out_vld)
endmodule
